// ----- rtl/bdrs_pkg.sv -----
// Shared constants for the block-decomposed range sum unit.
// No dependencies.
package bdrs_pkg;

  localparam int ELEMENTS   = 1024;
  localparam int BLOCK_SIZE = 32;
  localparam int NUM_BLOCKS = ELEMENTS / BLOCK_SIZE;

  localparam int IDX_W  = 10;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(ELEMENTS);
  localparam int BLK_SH = $clog2(BLOCK_SIZE);
  localparam int BLK_W  = ADDR_W - BLK_SH;
  localparam int CNT_W  = IDX_W + 1;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

endpackage

// ----- rtl/block_decomposed_range_sum_unit.sv -----
// Block-decomposed range sum unit: element RAM plus per-block running sums.
// Depends on bdrs_pkg and bdrs_ram.
//
// After reset the unit zeroes every element of the element RAM and is not
// ready during that pass. A write beat reads the old element, subtracts it
// from the block sum and folds in the new value; a write beyond the array is
// accepted and dropped. A query visits single elements and whole blocks in
// turn; all of it goes through one 32-bit adder fed by the element RAM's
// single port and the block sums. One beat is in work at a time; a finished
// sum sits in the output register while the next beat enters.
module block_decomposed_range_sum_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mode_i,
  input  logic [bdrs_pkg::IDX_W-1:0]          left_index_i,
  input  logic [bdrs_pkg::IDX_W-1:0]          right_index_i,
  input  logic signed [bdrs_pkg::DATA_W-1:0]  value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bdrs_pkg::DATA_W-1:0]  range_sum_o
);
  import bdrs_pkg::*;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_WRD,
    S_WSUB,
    S_WADD,
    S_QRY
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  i_q;
  logic [CNT_W-1:0]  hi_q;
  logic [DATA_W-1:0] acc_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] bsum_q;
  logic              pend_q;
  logic              src_blk_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_q;
  logic [DATA_W-1:0] block_sums_q [NUM_BLOCKS];

  logic              accept;
  logic [CNT_W-1:0]  left_ext;
  logic [CNT_W-1:0]  right_ext;
  logic [CNT_W-1:0]  right_sat;
  logic              in_range;
  logic [CNT_W:0]    blk_end;
  logic              use_blk;
  logic [BLK_W-1:0]  blk_idx;
  logic              out_free;
  logic              q_done;

  logic              ram_en;
  logic              ram_we;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  logic [DATA_W-1:0] add_a;
  logic [DATA_W-1:0] add_b;
  logic              add_c;
  logic [DATA_W-1:0] add_sum;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign range_sum_o = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign left_ext  = {1'b0, left_index_i};
  assign right_ext = {1'b0, right_index_i};
  assign right_sat = (right_ext >= CNT_W'(ELEMENTS)) ? CNT_W'(ELEMENTS - 1) : right_ext;

  assign in_range = (i_q <= hi_q);
  assign blk_end  = {1'b0, i_q} + (CNT_W + 1)'(BLOCK_SIZE - 1);
  assign use_blk  = (i_q[BLK_SH-1:0] == '0) && (blk_end <= {1'b0, hi_q});
  assign blk_idx  = i_q[ADDR_W-1:BLK_SH];
  assign q_done   = (state_q == S_QRY) && !in_range && !pend_q && out_free;

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = val_q;
    unique case (state_q)
      S_CLR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      S_WRD:  ram_en = 1'b1;
      S_WADD: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
      end
      S_QRY:  ram_en = in_range && !use_blk;
      default: ;
    endcase
  end

  bdrs_ram #(
    .WIDTH(DATA_W),
    .DEPTH(ELEMENTS)
  ) u_elem_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (i_q[ADDR_W-1:0]),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // shared adder
  always_comb begin
    add_a = acc_q;
    add_b = '0;
    add_c = 1'b0;
    unique case (state_q)
      S_WSUB: begin
        add_a = bsum_q;
        add_b = ~ram_rdata;
        add_c = 1'b1;
      end
      S_WADD: add_b = val_q;
      default: begin
        if (pend_q) begin
          add_b = src_blk_q ? bsum_q : ram_rdata;
        end
      end
    endcase
  end

  assign add_sum = add_a + add_b + {{(DATA_W - 1){1'b0}}, add_c};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      i_q         <= '0;
      hi_q        <= '0;
      acc_q       <= '0;
      val_q       <= '0;
      bsum_q      <= '0;
      pend_q      <= 1'b0;
      src_blk_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
        block_sums_q[b] <= '0;
      end
    end else begin
      if (q_done) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          if (i_q == CNT_W'(ELEMENTS - 1)) begin
            i_q     <= '0;
            state_q <= S_IDLE;
          end else begin
            i_q <= i_q + CNT_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            i_q    <= left_ext;
            hi_q   <= right_sat;
            val_q  <= value_i;
            acc_q  <= '0;
            pend_q <= 1'b0;
            if (mode_i == MODE_QUERY) begin
              state_q <= S_QRY;
            end else if (left_ext < CNT_W'(ELEMENTS)) begin
              state_q <= S_WRD;
            end
          end
        end
        S_WRD: begin
          bsum_q  <= block_sums_q[blk_idx];
          state_q <= S_WSUB;
        end
        S_WSUB: begin
          acc_q   <= add_sum;
          state_q <= S_WADD;
        end
        S_WADD: begin
          block_sums_q[blk_idx] <= add_sum;
          state_q               <= S_IDLE;
        end
        S_QRY: begin
          acc_q <= add_sum;
          if (in_range) begin
            pend_q <= 1'b1;
            if (use_blk) begin
              src_blk_q <= 1'b1;
              bsum_q    <= block_sums_q[blk_idx];
              i_q       <= i_q + CNT_W'(BLOCK_SIZE);
            end else begin
              src_blk_q <= 1'b0;
              i_q       <= i_q + CNT_W'(1);
            end
          end else begin
            pend_q <= 1'b0;
            if (q_done) begin
              out_q   <= acc_q;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_QRY) && pend_q) |-> (i_q <= hi_q + CNT_W'(1)))
    else $error("query walk ran past the range end");

  a_clr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> (ram_en && ram_we && (ram_wdata == '0)))
    else $error("clear pass not writing zero");

  a_out_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_QRY))
    else $error("result beat not produced by a query");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i == MODE_WRITE)) |=> ((state_q == S_WRD) || (state_q == S_IDLE)))
    else $error("write beat took a wrong path");

endmodule

// ----- rtl/bdrs_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module bdrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

// ----- tb/block_decomposed_range_sum_unit_test.sv -----
// Testbench for block_decomposed_range_sum_unit: drives write and range-sum beats,
// mirrors the element store and block sums, and checks every range_sum beat.
// Depends on bdrs_pkg and the unit's RTL.
`timescale 1ns / 100ps

module block_decomposed_range_sum_unit_test;
  import bdrs_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_BEATS = 1450;
  localparam int TAIL_CYCLES  = 200;
  localparam int HOLD_CYCLES  = 3000;

  typedef struct {
    logic              mode;
    logic [IDX_W-1:0]  left;
    logic [IDX_W-1:0]  right;
    logic [DATA_W-1:0] value;
    bit                wait_idle;
  } range_op_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic                     mode_i = MODE_WRITE;
  logic [IDX_W-1:0]         left_index_i = '0;
  logic [IDX_W-1:0]         right_index_i = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] range_sum_o;

  logic [DATA_W-1:0] elem_mirror [ELEMENTS];
  logic [DATA_W-1:0] block_mirror [NUM_BLOCKS];
  logic [DATA_W-1:0] expected_sums [$];
  range_op_t         pending_ops [$];
  range_op_t         live_op;
  bit                drain_next = 1'b0;

  int beats_accepted = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int ready_odds = 8;
  int ready_phase_left = 0;
  int hold_cycles_left = 0;
  bit hold_used = 1'b0;

  block_decomposed_range_sum_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .left_index_i  (left_index_i),
    .right_index_i (right_index_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .range_sum_o   (range_sum_o)
  );

  always #4 clk_i = ~clk_i;

  // Partial block element by element, then whole block sums, then the tail.
  function automatic logic [DATA_W-1:0] span_total(int unsigned lo, int unsigned hi);
    logic [DATA_W-1:0] acc;
    int unsigned pos;
    acc = '0;
    pos = lo;
    while (pos <= hi && (pos % BLOCK_SIZE) != 0) begin
      acc += elem_mirror[pos];
      pos++;
    end
    while (pos + BLOCK_SIZE - 1 <= hi) begin
      acc += block_mirror[pos / BLOCK_SIZE];
      pos += BLOCK_SIZE;
    end
    while (pos <= hi) begin
      acc += elem_mirror[pos];
      pos++;
    end
    return acc;
  endfunction

  task automatic absorb_op(input range_op_t op);
    int unsigned lo;
    int unsigned hi;
    lo = op.left;
    hi = op.right;
    if (op.mode == MODE_WRITE) begin
      if (lo < ELEMENTS) begin
        block_mirror[lo / BLOCK_SIZE] += op.value - elem_mirror[lo];
        elem_mirror[lo] = op.value;
      end
    end else begin
      if (hi >= ELEMENTS) hi = ELEMENTS - 1;
      if (lo < ELEMENTS && lo <= hi) expected_sums.push_back(span_total(lo, hi));
      else expected_sums.push_back('0);
    end
  endtask

  task automatic check_range_sum(input logic [DATA_W-1:0] actual);
    logic [DATA_W-1:0] want;
    if (expected_sums.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("unexpected range_sum beat: %h", actual);
    end else begin
      want = expected_sums.pop_front();
      if (want !== actual) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("range_sum mismatch: expected %h (%0d) actual %h (%0d)",
                   want, $signed(want), actual, $signed(actual));
      end
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(input logic mode, input int l, input int r, input logic [31:0] v);
    range_op_t op;
    op.mode = mode;
    op.left = IDX_W'(l);
    op.right = IDX_W'(r);
    op.value = v;
    op.wait_idle = drain_next;
    drain_next = 1'b0;
    pending_ops.push_back(op);
  endtask

  task automatic push_write(input int idx, input logic [31:0] v);
    push_op(MODE_WRITE, idx, $urandom_range(0, ELEMENTS - 1), v);
  endtask

  task automatic push_query(input int l, input int r);
    push_op(MODE_QUERY, l, r, $urandom);
  endtask

  task automatic push_random_query();
    int a;
    int b;
    int blk;
    a = $urandom_range(0, ELEMENTS - 1);
    b = $urandom_range(0, ELEMENTS - 1);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        if (a > b) push_query(b, a);
        else push_query(a, b);
      end
      3, 4: push_query(a, (a + $urandom_range(0, 40) > 1023) ? 1023 : a + $urandom_range(0, 40));
      5: begin
        blk = $urandom_range(0, NUM_BLOCKS - 1);
        push_query(blk * BLOCK_SIZE,
                   (blk + $urandom_range(1, NUM_BLOCKS - blk)) * BLOCK_SIZE - 1);
      end
      6: begin
        blk = $urandom_range(1, NUM_BLOCKS - 1);
        push_query(blk * BLOCK_SIZE - $urandom_range(0, 3), blk * BLOCK_SIZE + $urandom_range(0, 3));
      end
      7: push_query((a > 0) ? a : 1, $urandom_range(0, (a > 0) ? a - 1 : 0));
      8: push_query($urandom_range(0, 1) ? 0 : a, $urandom_range(0, 1) ? ELEMENTS - 1 : a);
      default: push_query(a, a);
    endcase
  endtask

  // sender: bursts of beats with random gaps, optional wait for idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        absorb_op(live_op);
        beats_accepted <= beats_accepted + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].wait_idle && expected_sums.size() != 0)) begin
          live_op = pending_ops.pop_front();
          mode_i <= live_op.mode;
          left_index_i <= live_op.left;
          right_index_i <= live_op.right;
          value_i <= live_op.value;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once traffic is flowing
  always @(posedge clk_i) begin
    if (hold_cycles_left != 0) begin
      hold_cycles_left <= hold_cycles_left - 1;
    end else if (!hold_used && beats_accepted >= 300) begin
      hold_used <= 1'b1;
      hold_cycles_left <= HOLD_CYCLES;
    end
  end

  // receiver: checks beats, stalls on a phase-varying pattern
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_range_sum(range_sum_o);
      if (ready_phase_left == 0) begin
        ready_phase_left = $urandom_range(32, 400);
        case ($urandom_range(0, 4))
          0, 1: ready_odds = 8;
          2: ready_odds = 4;
          3: ready_odds = 2;
          default: ready_odds = 1;
        endcase
      end else begin
        ready_phase_left--;
      end
      out_ready_i <= (hold_cycles_left == 0) && ($urandom_range(0, 7) < ready_odds);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    foreach (elem_mirror[i]) elem_mirror[i] = '0;
    foreach (block_mirror[i]) block_mirror[i] = '0;

    push_query(0, ELEMENTS - 1);
    push_write(0, 32'h7fff_ffff);
    push_write(ELEMENTS - 1, 32'h8000_0000);
    push_write(31, 32'hffff_ffff);
    push_write(32, 32'h7fff_ffff);
    push_query(0, ELEMENTS - 1);
    push_query(0, 0);
    push_query(ELEMENTS - 1, ELEMENTS - 1);
    push_query(31, 32);
    push_query(5, 3);
    push_query(ELEMENTS - 1, 0);
    push_write(0, 32'h8000_0000);
    push_query(0, 31);
    push_query(0, 63);
    push_query(1, ELEMENTS - 2);
    push_query(33, 62);
    push_write(500, 32'h0000_0001);
    push_query(480, 511);
    push_query(499, 501);
    push_write(ELEMENTS - 1, '0);
    push_query(992, ELEMENTS - 1);
    push_query(0, ELEMENTS - 1);
    drain_next = 1'b1;

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 700) drain_next = 1'b1;
      if ($urandom_range(0, 1) == 0) push_write($urandom_range(0, ELEMENTS - 1), pick_word());
      else push_random_query();
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_sums.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_sums.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bdrs_pkg.sv
rtl/bdrs_ram.sv
rtl/block_decomposed_range_sum_unit.sv
tb/block_decomposed_range_sum_unit_test.sv
